// ===== rtl/ilt_pkg.sv =====
`default_nettype none

package ilt_pkg;

    // Default number of CR and 0x04 bytes the hold store keeps.
    localparam int HOLD_DEPTH_DEF = 16;

    // At most this many results leave the block for one request,
    // the line end result included.
    localparam int OUT_CAP = 40;

    // Depths of the request queue and of the result queue (plus one head register each).
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    // Byte values the tokenizer looks for.
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_EOT   = 8'h04;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_END   = 2'd2,
        KIND_LINE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_CMD   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // One classified request on its way from the front end to the tokenizer.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       eol;
        logic       is_ctl;
        logic       is_cr;
        logic       is_space;
        logic       is_colon;
        logic       is_lf;
    } cmd_t;

    // One result item.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       is_arg;
        logic [7:0] arg_idx;
        status_t    status;
        logic       last;
    } res_t;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

// ===== rtl/ilt_fifo.sv =====
`default_nettype none

module ilt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] head_reg;
    logic             head_valid_reg, head_valid_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic push_ok;
    logic pop_ok;
    logic head_free;
    logic load_mem;
    logic load_in;
    logic mem_we;

    // The head register shows the oldest entry; the array holds the rest.
    always_comb
    begin
        push_ok   = push && !full;
        pop_ok    = pop && head_valid_reg;
        head_free = !head_valid_reg || pop_ok;
        load_mem  = head_free && (count_reg != '0);
        load_in   = head_free && (count_reg == '0) && push_ok;
        mem_we    = push_ok && !load_in;

        head_valid_next = head_free ? (load_mem || load_in) : 1'b1;

        wr_ptr_next = wr_ptr_reg;
        if (mem_we)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end

        rd_ptr_next = rd_ptr_reg;
        if (load_mem)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end

        count_next = count_reg;
        if (mem_we && !load_mem)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!mem_we && load_mem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers, fill count and head flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    // Storage and head data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (load_mem)
        begin
            head_reg <= mem[rd_ptr_reg];
        end
        else if (load_in)
        begin
            head_reg <= wdata;
        end
    end

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = !head_valid_reg;
    assign rdata = head_reg;

endmodule

`default_nettype wire

// ===== rtl/ilt_front.sv =====
`default_nettype none

module ilt_front (
    input  wire logic        push,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        end_of_line,
    output logic             full,
    input  wire logic        cmd_full,
    output logic             cmd_push,
    output ilt_pkg::cmd_t    cmd
);

    import ilt_pkg::*;

    logic useful;

    // A request with neither a byte nor a line end changes nothing, so it is
    // taken and dropped here.
    assign useful   = has_byte || end_of_line;
    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full && useful;

    // Classify the byte once so the tokenizer only tests flags.
    always_comb
    begin
        cmd.data     = data_byte;
        cmd.has_byte = has_byte;
        cmd.eol      = end_of_line;
        cmd.is_cr    = has_byte && (data_byte == CHAR_CR);
        cmd.is_ctl   = has_byte && ((data_byte == CHAR_CR) || (data_byte == CHAR_EOT));
        cmd.is_space = (data_byte == CHAR_SPACE)
                       || ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
        cmd.is_colon = (data_byte == CHAR_COLON);
        cmd.is_lf    = (data_byte == CHAR_LF);
    end

endmodule

`default_nettype wire

// ===== rtl/ilt_back.sv =====
`default_nettype none

module ilt_back #(
    parameter int HOLD_DEPTH = ilt_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_empty,
    input  wire ilt_pkg::cmd_t  cmd,
    output logic                cmd_pop,
    input  wire logic           res_full,
    output logic                res_push,
    output ilt_pkg::res_t       res_data
);

    import ilt_pkg::*;

    localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int N_W   = $clog2(OUT_CAP + 1);

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_RELEASE,
        SQ_BYTE,
        SQ_SECOND,
        SQ_EOL_TOK,
        SQ_EOL_LINE,
        SQ_FLUSH
    } seq_t;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SEEK_CMD,
        PH_IN_CMD,
        PH_SEEK_ARG,
        PH_IN_ARG,
        PH_TRAIL,
        PH_DONE
    } phase_t;

    seq_t              state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [HOLD_DEPTH-1:0] held_kinds_reg, held_kinds_next;
    logic [CNT_W-1:0]  held_count_reg, held_count_next;
    logic [IDX_W-1:0]  rel_idx_reg, rel_idx_next;
    logic [7:0]        arg_count_reg, arg_count_next;
    logic              in_token_reg, in_token_next;
    logic              have_cmd_reg, have_cmd_next;
    logic              overflow_reg, overflow_next;
    logic              has_bytes_reg, has_bytes_next;
    logic [7:0]        item_byte_reg, item_byte_next;
    logic              item_sp_reg, item_sp_next;
    logic              item_colon_reg, item_colon_next;
    logic              item_lf_reg, item_lf_next;
    logic              item_eol_reg, item_eol_next;
    logic [7:0]        sec_byte_reg, sec_byte_next;
    logic              sec_rel_reg, sec_rel_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic              pend_valid_reg, pend_valid_next;
    res_t              pend_reg, pend_next;

    logic       proceed;
    logic       gen_req;
    logic       gen_capped;
    res_t       gen_res;
    logic       finish;
    logic       fin_rel;
    logic [7:0] arg_inc;

    // Byte fed to the tokenizer: a released held byte or the request byte.
    logic       held_bit;
    logic [7:0] f_byte;
    logic       f_sp;
    logic       f_colon;
    logic       f_lf;

    assign held_bit = held_kinds_reg[rel_idx_reg];
    assign arg_inc  = (arg_count_reg == 8'hFF) ? arg_count_reg : arg_count_reg + 8'd1;
    // A new result moves the pending one out, so the result queue needs room.
    assign proceed  = !pend_valid_reg || !res_full;

    always_comb
    begin
        if (state_reg == SQ_RELEASE)
        begin
            f_byte  = held_bit ? CHAR_CR : CHAR_EOT;
            f_sp    = held_bit;
            f_colon = 1'b0;
            f_lf    = 1'b0;
        end
        else
        begin
            f_byte  = item_byte_reg;
            f_sp    = item_sp_reg;
            f_colon = item_colon_reg;
            f_lf    = item_lf_reg;
        end
    end

    // Sequencer: one tokenizer step and at most one new result per cycle unless it stalls.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        held_kinds_next = held_kinds_reg;
        held_count_next = held_count_reg;
        rel_idx_next    = rel_idx_reg;
        arg_count_next  = arg_count_reg;
        in_token_next   = in_token_reg;
        have_cmd_next   = have_cmd_reg;
        overflow_next   = overflow_reg;
        has_bytes_next  = has_bytes_reg;
        item_byte_next  = item_byte_reg;
        item_sp_next    = item_sp_reg;
        item_colon_next = item_colon_reg;
        item_lf_next    = item_lf_reg;
        item_eol_next   = item_eol_reg;
        sec_byte_next   = sec_byte_reg;
        sec_rel_next    = sec_rel_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res_data   = pend_reg;
        gen_req    = 1'b0;
        gen_capped = 1'b1;
        gen_res    = '0;
        finish     = 1'b0;
        fin_rel    = 1'b0;

        case (state_reg)
            SQ_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop         = 1'b1;
                    item_byte_next  = cmd.data;
                    item_sp_next    = cmd.is_space;
                    item_colon_next = cmd.is_colon;
                    item_lf_next    = cmd.is_lf;
                    item_eol_next   = cmd.eol;
                    n_next          = '0;
                    if (cmd.has_byte)
                    begin
                        has_bytes_next = 1'b1;
                        if (cmd.is_ctl)
                        begin
                            // Hold CR and 0x04 inside the line until it is known
                            // whether they trail.
                            if ((phase_reg != PH_LEAD) && (phase_reg != PH_DONE))
                            begin
                                if (held_count_reg < CNT_W'(HOLD_DEPTH))
                                begin
                                    held_kinds_next[held_count_reg[IDX_W-1:0]] = cmd.is_cr;
                                    held_count_next = held_count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    overflow_next = 1'b1;
                                end
                            end
                            state_next = cmd.eol ? SQ_EOL_TOK : SQ_IDLE;
                        end
                        else
                        begin
                            if (phase_reg == PH_LEAD)
                            begin
                                phase_next = PH_SEEK_CMD;
                            end
                            rel_idx_next = '0;
                            state_next   = (held_count_reg != '0) ? SQ_RELEASE : SQ_BYTE;
                        end
                    end
                    else
                    begin
                        state_next = cmd.eol ? SQ_EOL_TOK : SQ_IDLE;
                    end
                end
            end

            SQ_RELEASE, SQ_BYTE:
            begin
                if (proceed)
                begin
                    case (phase_reg)
                        PH_SEEK_CMD:
                        begin
                            if (!f_sp)
                            begin
                                gen_req        = 1'b1;
                                gen_res.kind   = KIND_START;
                                have_cmd_next  = 1'b1;
                                in_token_next  = 1'b1;
                                phase_next     = PH_IN_CMD;
                            end
                        end
                        PH_IN_CMD:
                        begin
                            gen_req = 1'b1;
                            if (f_sp)
                            begin
                                gen_res.kind  = KIND_END;
                                in_token_next = 1'b0;
                                phase_next    = PH_SEEK_ARG;
                            end
                            else
                            begin
                                gen_res.kind = KIND_BYTE;
                                gen_res.data = f_byte;
                            end
                        end
                        PH_SEEK_ARG:
                        begin
                            if (!f_sp)
                            begin
                                gen_req         = 1'b1;
                                gen_res.kind    = KIND_START;
                                gen_res.is_arg  = 1'b1;
                                gen_res.arg_idx = arg_count_reg;
                                in_token_next   = 1'b1;
                                phase_next      = f_colon ? PH_TRAIL : PH_IN_ARG;
                            end
                        end
                        PH_IN_ARG:
                        begin
                            gen_req         = 1'b1;
                            gen_res.is_arg  = 1'b1;
                            gen_res.arg_idx = arg_count_reg;
                            if (f_sp)
                            begin
                                gen_res.kind   = KIND_END;
                                arg_count_next = arg_inc;
                                in_token_next  = 1'b0;
                                phase_next     = PH_SEEK_ARG;
                            end
                            else
                            begin
                                gen_res.kind = KIND_BYTE;
                                gen_res.data = f_byte;
                            end
                        end
                        PH_TRAIL:
                        begin
                            gen_req         = 1'b1;
                            gen_res.is_arg  = 1'b1;
                            gen_res.arg_idx = arg_count_reg;
                            if (f_lf)
                            begin
                                gen_res.kind   = KIND_END;
                                arg_count_next = arg_inc;
                                in_token_next  = 1'b0;
                                phase_next     = PH_DONE;
                            end
                            else
                            begin
                                gen_res.kind = KIND_BYTE;
                                gen_res.data = f_byte;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // A token start that carries its first byte goes on to SQ_SECOND for that byte.
                    if (!f_sp && ((phase_reg == PH_SEEK_CMD)
                                  || ((phase_reg == PH_SEEK_ARG) && !f_colon)))
                    begin
                        sec_byte_next = f_byte;
                        sec_rel_next  = (state_reg == SQ_RELEASE);
                        state_next    = SQ_SECOND;
                    end
                    else
                    begin
                        finish  = 1'b1;
                        fin_rel = (state_reg == SQ_RELEASE);
                    end
                end
            end

            SQ_SECOND:
            begin
                if (proceed)
                begin
                    gen_req      = 1'b1;
                    gen_res.kind = KIND_BYTE;
                    gen_res.data = sec_byte_reg;
                    if (phase_reg == PH_IN_ARG)
                    begin
                        gen_res.is_arg  = 1'b1;
                        gen_res.arg_idx = arg_count_reg;
                    end
                    finish  = 1'b1;
                    fin_rel = sec_rel_reg;
                end
            end

            SQ_EOL_TOK:
            begin
                if (proceed)
                begin
                    // Close a token left open at the line end.
                    if (in_token_reg)
                    begin
                        gen_req      = 1'b1;
                        gen_res.kind = KIND_END;
                        if (phase_reg != PH_IN_CMD)
                        begin
                            gen_res.is_arg  = 1'b1;
                            gen_res.arg_idx = arg_count_reg;
                            arg_count_next  = arg_inc;
                        end
                    end
                    state_next = SQ_EOL_LINE;
                end
            end

            SQ_EOL_LINE:
            begin
                if (proceed)
                begin
                    gen_req         = 1'b1;
                    gen_capped      = 1'b0;
                    gen_res.kind    = KIND_LINE;
                    gen_res.arg_idx = arg_count_reg;
                    if (!has_bytes_reg)
                    begin
                        gen_res.status = ST_EMPTY;
                    end
                    else if (overflow_reg)
                    begin
                        gen_res.status = ST_OVERFLOW;
                    end
                    else if (!have_cmd_reg)
                    begin
                        gen_res.status = ST_NO_CMD;
                    end
                    else
                    begin
                        gen_res.status = ST_OK;
                    end
                    // Back to the state of a fresh line.
                    phase_next      = PH_LEAD;
                    held_kinds_next = '0;
                    held_count_next = '0;
                    arg_count_next  = '0;
                    in_token_next   = 1'b0;
                    have_cmd_next   = 1'b0;
                    overflow_next   = 1'b0;
                    has_bytes_next  = 1'b0;
                    state_next      = SQ_FLUSH;
                end
            end

            SQ_FLUSH:
            begin
                // The pending result is the last one of this request.
                if (!pend_valid_reg)
                begin
                    state_next = SQ_IDLE;
                end
                else if (!res_full)
                begin
                    res_push        = 1'b1;
                    res_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = SQ_IDLE;
                end
            end

            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase

        // End of one fed byte: step through the held run, then the request byte.
        if (finish)
        begin
            if (fin_rel)
            begin
                if (CNT_W'(rel_idx_reg) == held_count_reg - CNT_W'(1))
                begin
                    held_kinds_next = '0;
                    held_count_next = '0;
                    state_next      = SQ_BYTE;
                end
                else
                begin
                    rel_idx_next = rel_idx_reg + IDX_W'(1);
                    state_next   = SQ_RELEASE;
                end
            end
            else
            begin
                state_next = item_eol_reg ? SQ_EOL_TOK : SQ_FLUSH;
            end
        end

        // A new result either is dropped for lack of room or becomes pending.
        if (gen_req)
        begin
            if (gen_capped && (n_reg >= N_W'(OUT_CAP - 1)))
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                if (pend_valid_reg)
                begin
                    res_push      = 1'b1;
                    res_data.last = 1'b0;
                end
                pend_next       = gen_res;
                pend_valid_next = 1'b1;
                n_next          = n_reg + N_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SQ_IDLE;
            phase_reg      <= PH_LEAD;
            held_kinds_reg <= '0;
            held_count_reg <= '0;
            rel_idx_reg    <= '0;
            arg_count_reg  <= '0;
            in_token_reg   <= 1'b0;
            have_cmd_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            has_bytes_reg  <= 1'b0;
            item_byte_reg  <= '0;
            item_sp_reg    <= 1'b0;
            item_colon_reg <= 1'b0;
            item_lf_reg    <= 1'b0;
            item_eol_reg   <= 1'b0;
            sec_byte_reg   <= '0;
            sec_rel_reg    <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            held_kinds_reg <= held_kinds_next;
            held_count_reg <= held_count_next;
            rel_idx_reg    <= rel_idx_next;
            arg_count_reg  <= arg_count_next;
            in_token_reg   <= in_token_next;
            have_cmd_reg   <= have_cmd_next;
            overflow_reg   <= overflow_next;
            has_bytes_reg  <= has_bytes_next;
            item_byte_reg  <= item_byte_next;
            item_sp_reg    <= item_sp_next;
            item_colon_reg <= item_colon_next;
            item_lf_reg    <= item_lf_next;
            item_eol_reg   <= item_eol_next;
            sec_byte_reg   <= sec_byte_next;
            sec_rel_reg    <= sec_rel_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_W'(HOLD_DEPTH))
        else $error("hold store count beyond its depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_IDLE) |-> !pend_valid_reg)
        else $error("result left pending between requests");

    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == SQ_EOL_LINE) && proceed) |=>
            ((phase_reg == PH_LEAD) && (held_count_reg == '0) && pend_valid_reg))
        else $error("line end did not restore the line state");
`endif

endmodule

`default_nettype wire

// ===== rtl/irc_line_tokenizer_unit.sv =====
`default_nettype none

// Line tokenizer. Requests (one byte of a line, or a line end) are written
// through push/full and results are read through empty/pop, both as queues.
// A front end classifies each request into a five-entry queue; the tokenizer
// behind it splits the line into a command and arguments, holds interior runs
// of CR and 0x04 bytes (up to HOLD_DEPTH) and writes results into a
// five-entry result queue. The tokenizer handles one request at a time and
// produces at most one result per cycle. An ordinary byte passes through
// fetch, tokenize and hand-off of its final result; each released held byte
// adds a release step, a byte that opens a token adds a step for its first
// byte, and a line end adds a token close step and a line result step. A full
// result queue stalls the tokenizer, and a full request queue raises full.
module irc_line_tokenizer_unit #(
    parameter int HOLD_DEPTH = ilt_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       has_byte,
    input  wire logic       end_of_line,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      kind,
    output logic [7:0]      out_byte,
    output logic            is_argument,
    output logic [7:0]      arg_index,
    output logic [1:0]      line_status,
    output logic            last
);

    import ilt_pkg::*;

    cmd_t             cmd_in;
    cmd_t             cmd_head;
    logic             cmd_push;
    logic             cmd_full;
    logic             cmd_empty;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_rdata;
    res_t             res_in;
    res_t             res_head;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_rdata;

    ilt_front u_front (
        .push        (push),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .end_of_line (end_of_line),
        .full        (full),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    ilt_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_rdata)
    );

    assign cmd_head = cmd_rdata;

    ilt_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    ilt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .empty (empty),
        .rdata (res_rdata)
    );

    // Unpack the oldest result onto the ports.
    assign res_head    = res_rdata;
    assign kind        = res_head.kind;
    assign out_byte    = res_head.data;
    assign is_argument = res_head.is_arg;
    assign arg_index   = res_head.arg_idx;
    assign line_status = res_head.status;
    assign last        = res_head.last;

endmodule

`default_nettype wire

// ===== bench/irc_line_tokenizer_unit_test.sv =====
`default_nettype none

module irc_line_tokenizer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ilt_pkg::*;

    // Where the tokenizer stands within the current line.
    typedef enum int {
        SCAN_LEAD,
        SCAN_SEEK_CMD,
        SCAN_IN_CMD,
        SCAN_SEEK_ARG,
        SCAN_IN_ARG,
        SCAN_TRAIL,
        SCAN_DONE
    } scan_phase_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic       is_arg;
        logic [7:0] arg_idx;
        status_t    status;
        logic       last;
    } token_result_t;

    typedef logic [7:0] line_bytes_t[$];

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'h00;
    logic       has_byte = 1'b0;
    logic       end_of_line = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       is_argument;
    logic [7:0] arg_index;
    logic [1:0] line_status;
    logic       last;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int requests_sent = 0;

    // Whitespace that separates tokens.
    function automatic bit is_blank(logic [7:0] b);
        return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

    // Tracks the tokenizer state and keeps the results it still owes.
    class token_scoreboard;
        token_result_t expected_q[$];
        token_result_t step_q[$];
        scan_phase_t   phase;
        logic [63:0]   held_kinds;
        int            held_count;
        int            arg_count;
        bit            in_token;
        bit            have_command;
        bit            hold_overflow;
        bit            line_has_bytes;
        int            errors;

        function new();
            clear_line();
            errors = 0;
        endfunction

        function void clear_line();
            phase = SCAN_LEAD;
            held_kinds = '0;
            held_count = 0;
            arg_count = 0;
            in_token = 0;
            have_command = 0;
            hold_overflow = 0;
            line_has_bytes = 0;
        endfunction

        // A result that would crowd out the line end is dropped and flags the line.
        function void emit(kind_t k, logic [7:0] d, logic isarg, logic [7:0] idx);
            token_result_t r;
            if (step_q.size() >= OUT_CAP - 1)
            begin
                hold_overflow = 1;
                return;
            end
            r.kind = k;
            r.data = d;
            r.is_arg = isarg;
            r.arg_idx = idx;
            r.status = ST_OK;
            r.last = 1'b0;
            step_q.insert(step_q.size(), r);
        endfunction

        function void count_argument();
            if (arg_count < 255)
                arg_count++;
        endfunction

        // One byte through the token splitter.
        function void feed(logic [7:0] b);
            bit sp;
            sp = is_blank(b);
            case (phase)
                SCAN_SEEK_CMD:
                begin
                    if (!sp)
                    begin
                        emit(KIND_START, 8'h00, 1'b0, 8'h00);
                        emit(KIND_BYTE, b, 1'b0, 8'h00);
                        have_command = 1;
                        in_token = 1;
                        phase = SCAN_IN_CMD;
                    end
                end
                SCAN_IN_CMD:
                begin
                    if (sp)
                    begin
                        emit(KIND_END, 8'h00, 1'b0, 8'h00);
                        in_token = 0;
                        phase = SCAN_SEEK_ARG;
                    end
                    else
                    begin
                        emit(KIND_BYTE, b, 1'b0, 8'h00);
                    end
                end
                SCAN_SEEK_ARG:
                begin
                    if (!sp)
                    begin
                        emit(KIND_START, 8'h00, 1'b1, arg_count[7:0]);
                        in_token = 1;
                        if (b == CHAR_COLON)
                        begin
                            phase = SCAN_TRAIL;
                        end
                        else
                        begin
                            emit(KIND_BYTE, b, 1'b1, arg_count[7:0]);
                            phase = SCAN_IN_ARG;
                        end
                    end
                end
                SCAN_IN_ARG:
                begin
                    if (sp)
                    begin
                        emit(KIND_END, 8'h00, 1'b1, arg_count[7:0]);
                        count_argument();
                        in_token = 0;
                        phase = SCAN_SEEK_ARG;
                    end
                    else
                    begin
                        emit(KIND_BYTE, b, 1'b1, arg_count[7:0]);
                    end
                end
                SCAN_TRAIL:
                begin
                    if (b == CHAR_LF)
                    begin
                        emit(KIND_END, 8'h00, 1'b1, arg_count[7:0]);
                        count_argument();
                        in_token = 0;
                        phase = SCAN_DONE;
                    end
                    else
                    begin
                        emit(KIND_BYTE, b, 1'b1, arg_count[7:0]);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Works out the results of one accepted request.
        function void note_request(logic [7:0] b, logic hb, logic eol);
            token_result_t r;
            step_q.delete();
            if (hb)
            begin
                line_has_bytes = 1;
                if (b == CHAR_CR || b == CHAR_EOT)
                begin
                    // CR and 0x04 inside a line wait for a later ordinary byte.
                    if (phase != SCAN_LEAD && phase != SCAN_DONE)
                    begin
                        if (held_count < HOLD_DEPTH_DEF)
                        begin
                            held_kinds[held_count] = (b == CHAR_CR);
                            held_count++;
                        end
                        else
                        begin
                            hold_overflow = 1;
                        end
                    end
                end
                else
                begin
                    if (phase == SCAN_LEAD)
                        phase = SCAN_SEEK_CMD;
                    for (int i = 0; i < held_count; i++)
                        feed(held_kinds[i] ? CHAR_CR : CHAR_EOT);
                    held_kinds = '0;
                    held_count = 0;
                    feed(b);
                end
            end

            if (eol)
            begin
                if (in_token)
                begin
                    if (phase == SCAN_IN_CMD)
                    begin
                        emit(KIND_END, 8'h00, 1'b0, 8'h00);
                    end
                    else
                    begin
                        emit(KIND_END, 8'h00, 1'b1, arg_count[7:0]);
                        count_argument();
                    end
                end
                r.kind = KIND_LINE;
                r.data = 8'h00;
                r.is_arg = 1'b0;
                r.arg_idx = arg_count[7:0];
                r.last = 1'b0;
                if (!line_has_bytes)
                    r.status = ST_EMPTY;
                else if (hold_overflow)
                    r.status = ST_OVERFLOW;
                else if (!have_command)
                    r.status = ST_NO_CMD;
                else
                    r.status = ST_OK;
                step_q.insert(step_q.size(), r);
                clear_line();
            end

            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                expected_q.insert(expected_q.size(), step_q[i]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compares one popped result with the oldest one owed.
        function void check_result(token_result_t got);
            token_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                         $time, got.kind, got.data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 8'(want.kind), 8'(got.kind));
            compare_field("out_byte", want.data, got.data);
            compare_field("is_argument", 8'(want.is_arg), 8'(got.is_arg));
            compare_field("arg_index", want.arg_idx, got.arg_idx);
            compare_field("line_status", 8'(want.status), 8'(got.status));
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    token_scoreboard scoreboard = new();

    irc_line_tokenizer_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .end_of_line(end_of_line),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .out_byte   (out_byte),
        .is_argument(is_argument),
        .arg_index  (arg_index),
        .line_status(line_status),
        .last       (last)
    );

    always #6 clk = ~clk;

    // The result side stalls at random.
    always @(negedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Every popped result goes to the scoreboard.
    always @(posedge clk)
    begin
        token_result_t got;
        if (rst_n && pop && !empty)
        begin
            got.kind = kind_t'(kind);
            got.data = out_byte;
            got.is_arg = is_argument;
            got.arg_idx = arg_index;
            got.status = status_t'(line_status);
            got.last = last;
            scoreboard.check_result(got);
        end
    end

    // Offers one request, after a random idle gap, and waits until it is taken.
    task automatic send_request(input logic [7:0] b, input logic hb, input logic eol);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        has_byte <= hb;
        end_of_line <= eol;
        do
            @(posedge clk);
        while (full);
        scoreboard.note_request(b, hb, eol);
        if (hb || eol)
            requests_sent++;
        @(negedge clk);
    endtask

    // Sends a line, with a stray empty request now and then.
    task automatic send_line(input line_bytes_t body, input bit bare_end);
        for (int i = 0; i < body.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(body[i], 1'b1, !bare_end && i == body.size() - 1);
        end
        if (bare_end || body.size() == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Puts one byte at the tail of a line.
    function automatic void append_byte(ref line_bytes_t q, input logic [7:0] b);
        q.insert(q.size(), b);
    endfunction

    function automatic void add_text(ref line_bytes_t q, input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(q, s[i]);
    endfunction

    function automatic void add_ctl_run(ref line_bytes_t q, input int len);
        for (int i = 0; i < len; i++)
            append_byte(q, $urandom_range(0, 1) ? CHAR_CR : CHAR_EOT);
    endfunction

    // Mostly short runs, now and then a long one near or past the hold depth.
    function automatic int ctl_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(HOLD_DEPTH_DEF - 2, HOLD_DEPTH_DEF + 4);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_blank(b) || b == CHAR_CR || b == CHAR_EOT);
        return b;
    endfunction

    function automatic void add_word(ref line_bytes_t q);
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(0, 9) == 0)
                add_ctl_run(q, ctl_len());
            append_byte(q, token_byte());
        end
    endfunction

    function automatic void add_gap(ref line_bytes_t q);
        int len;
        logic [7:0] blanks[5];
        blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, 8'h0B, 8'h0C};
        len = $urandom_range(1, 2);
        if ($urandom_range(0, 5) == 0)
            add_ctl_run(q, ctl_len());
        for (int i = 0; i < len; i++)
            append_byte(q, ($urandom_range(0, 2) == 0) ? blanks[$urandom_range(0, 4)]
                                                        : CHAR_SPACE);
    endfunction

    // A random line: mostly command and arguments, some noise.
    function automatic void build_line(ref line_bytes_t q);
        int shape;
        int nargs;
        int len;
        q.delete();
        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                append_byte(q, 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
            add_ctl_run(q, $urandom_range(1, 3));
        if ($urandom_range(0, 1) == 0)
            add_gap(q);
        if (shape < 14)
            return;
        add_word(q);
        nargs = $urandom_range(0, 5);
        for (int i = 0; i < nargs; i++)
        begin
            add_gap(q);
            add_word(q);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            // Trailing argument, sometimes closed by a newline with junk after it.
            add_gap(q);
            append_byte(q, CHAR_COLON);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
                append_byte(q, ($urandom_range(0, 3) == 0) ? CHAR_SPACE
                                                            : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0)
            begin
                append_byte(q, CHAR_LF);
                add_word(q);
            end
        end
        if ($urandom_range(0, 2) == 0)
            add_ctl_run(q, ctl_len());
    endfunction

    initial
    begin
        line_bytes_t body;
        int          next_switch;
        int          idle_sel;
        int          send_pcts[4];
        int          recv_pcts[4];

        send_pcts = '{0, 74, 0, 13};
        recv_pcts = '{0, 0, 74, 13};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty line.
        body.delete();
        send_line(body, 1'b1);

        // Leading CR and 0x04, a command that starts with a colon, 0x04 inside it,
        // a CR as separator, a trailing argument with a space, newline, ignored rest.
        body.delete();
        append_byte(body, CHAR_CR);
        append_byte(body, CHAR_EOT);
        append_byte(body, CHAR_COLON);
        append_byte(body, 8'hFF);
        append_byte(body, CHAR_EOT);
        append_byte(body, 8'h00);
        append_byte(body, CHAR_CR);
        append_byte(body, CHAR_COLON);
        append_byte(body, CHAR_SPACE);
        append_byte(body, CHAR_LF);
        append_byte(body, 8'h5A);
        append_byte(body, CHAR_CR);
        send_line(body, 1'b1);

        // Whitespace only: no command.
        body.delete();
        add_text(body, " \t");
        send_line(body, 1'b0);

        // Trailing CR and 0x04 are dropped; the argument ends at the line end.
        body.delete();
        add_text(body, "A b");
        append_byte(body, CHAR_CR);
        append_byte(body, CHAR_EOT);
        send_line(body, 1'b0);

        // An empty request between lines gives nothing.
        send_request(8'hA5, 1'b0, 1'b0);

        // Hold store overflow.
        body.delete();
        add_text(body, "X");
        for (int i = 0; i <= HOLD_DEPTH_DEF; i++)
            append_byte(body, CHAR_CR);
        add_text(body, "Y");
        send_line(body, 1'b0);

        // Random lines through the idling phases.
        next_switch = requests_sent;
        idle_sel = 0;
        while (requests_sent < 410)
        begin
            if (requests_sent >= next_switch)
            begin
                send_idle_pct = send_pcts[idle_sel];
                recv_stall_pct = recv_pcts[idle_sel];
                idle_sel = (idle_sel + 1) % 4;
                next_switch = requests_sent + 50;
            end
            build_line(body);
            send_line(body, $urandom_range(0, 3) == 0);
        end

        // Drain everything still owed, then watch for stray results.
        push <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("irc_line_tokenizer_unit_test: PASS");
        else
            $display("irc_line_tokenizer_unit_test: FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #10_000_000;
        $display("irc_line_tokenizer_unit_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
